@@ src/onu_pkg.sv @@
// Package for the octant navigation unit: command codes, neighbor selector codes,
// level limits and the geometry result struct. Depends on nothing.
package onu_pkg;

  // Finest refinement level; the side length of an octant is 2^(MaxLevel - level).
  localparam int unsigned MaxLevel = 30;

  localparam int unsigned CoordW = 30;
  localparam int unsigned OutW   = 32;
  localparam int unsigned LevelW = 5;
  localparam int unsigned SelW   = 4;
  localparam int unsigned OrderW = 6;

  typedef enum logic [2:0] {
    CmdChild      = 3'd0,
    CmdSibling    = 3'd1,
    CmdParent     = 3'd2,
    CmdFace       = 3'd3,
    CmdEdge       = 3'd4,
    CmdCorner     = 3'd5,
    CmdCompare    = 3'd6,
    CmdEncCompare = 3'd7
  } cmd_e;

  // Face selector codes.
  localparam logic [SelW-1:0] FaceXNeg = 4'd0;
  localparam logic [SelW-1:0] FaceXPos = 4'd1;
  localparam logic [SelW-1:0] FaceYNeg = 4'd2;
  localparam logic [SelW-1:0] FaceYPos = 4'd3;
  localparam logic [SelW-1:0] FaceZNeg = 4'd4;
  localparam logic [SelW-1:0] FaceZPos = 4'd5;

  // Edge selector group boundaries: edges along x, then y, then z.
  localparam logic [SelW-1:0] EdgeXHigh  = 4'd2;
  localparam logic [SelW-1:0] EdgeYFirst = 4'd4;
  localparam logic [SelW-1:0] EdgeYHigh  = 4'd6;
  localparam logic [SelW-1:0] EdgeZFirst = 4'd8;
  localparam logic [SelW-1:0] EdgeZHigh  = 4'd10;

  typedef struct packed {
    logic signed [OutW-1:0] x;
    logic signed [OutW-1:0] y;
    logic signed [OutW-1:0] z;
    logic [LevelW-1:0]      level;
    logic [2:0]             child;
    logic                   no_parent;
  } geo_res_t;

endpackage

@@ src/octant_navigation_unit.sv @@
// Top level of the octant navigation unit: input register, geometry and Morton
// datapaths, result register. Depends on onu_pkg, onu_geom and onu_morton.
//
//   channel   handshake               words carried
//   -------   ---------------------   ---------------------------------------------
//   command   start / busy            command, pos_x/y/z, depth_level, which,
//                                     other_x/y/z, other_level
//   result    result_valid_o strobe   out_x/y/z, out_level, child_index, order,
//                                     no_parent
//
// A command word is taken at every rising edge where start is high; busy is held
// low because both datapaths are purely combinational between two registers.
// Each word passes through the input register and the result register; one word
// per cycle flows through continuously. The receiver cannot stall, so the result
// register reloads for every valid word and result_valid_o is high for one cycle
// per word. Reset clears only the two valid flags; payload registers are left free.
module octant_navigation_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [2:0]                         command_i,
  input  logic [onu_pkg::CoordW-1:0]         pos_x_i,
  input  logic [onu_pkg::CoordW-1:0]         pos_y_i,
  input  logic [onu_pkg::CoordW-1:0]         pos_z_i,
  input  logic [onu_pkg::LevelW-1:0]         depth_level_i,
  input  logic [onu_pkg::SelW-1:0]           which_i,
  input  logic [onu_pkg::CoordW-1:0]         other_x_i,
  input  logic [onu_pkg::CoordW-1:0]         other_y_i,
  input  logic [onu_pkg::CoordW-1:0]         other_z_i,
  input  logic [onu_pkg::LevelW-1:0]         other_level_i,
  output logic                               result_valid_o,
  output logic signed [onu_pkg::OutW-1:0]    out_x_o,
  output logic signed [onu_pkg::OutW-1:0]    out_y_o,
  output logic signed [onu_pkg::OutW-1:0]    out_z_o,
  output logic [onu_pkg::LevelW-1:0]         out_level_o,
  output logic [2:0]                         child_index_o,
  output logic signed [onu_pkg::OrderW-1:0]  order_o,
  output logic                               no_parent_o
);

  // Input register stage.
  logic                          in_valid_q;
  onu_pkg::cmd_e                 cmd_q;
  logic [onu_pkg::CoordW-1:0]    pos_x_q, pos_y_q, pos_z_q;
  logic [onu_pkg::CoordW-1:0]    oth_x_q, oth_y_q, oth_z_q;
  logic [onu_pkg::LevelW-1:0]    level_q, oth_level_q;
  logic [onu_pkg::SelW-1:0]      which_q;
  logic                          accept;

  // Combinational results and the result register.
  onu_pkg::geo_res_t                 geo_d, geo_q;
  logic signed [onu_pkg::OrderW-1:0] order_d, order_q;
  logic                              out_valid_q;

  // Nothing ever holds a command off.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q       <= onu_pkg::cmd_e'(command_i);
      pos_x_q     <= pos_x_i;
      pos_y_q     <= pos_y_i;
      pos_z_q     <= pos_z_i;
      level_q     <= depth_level_i;
      which_q     <= which_i;
      oth_x_q     <= other_x_i;
      oth_y_q     <= other_y_i;
      oth_z_q     <= other_z_i;
      oth_level_q <= other_level_i;
    end
  end

  // Neighbor, sibling, parent and child-index arithmetic: one shift and one add per axis.
  onu_geom u_geom (
    .cmd_i   (cmd_q),
    .pos_x_i (pos_x_q),
    .pos_y_i (pos_y_q),
    .pos_z_i (pos_z_q),
    .level_i (level_q),
    .which_i (which_q),
    .res_o   (geo_d)
  );

  // Morton comparison: leading-axis selection then one magnitude compare.
  onu_morton u_morton (
    .cmd_i         (cmd_q),
    .pos_x_i       (pos_x_q),
    .pos_y_i       (pos_y_q),
    .pos_z_i       (pos_z_q),
    .level_i       (level_q),
    .other_x_i     (oth_x_q),
    .other_y_i     (oth_y_q),
    .other_z_i     (oth_z_q),
    .other_level_i (oth_level_q),
    .order_o       (order_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      geo_q   <= geo_d;
      order_q <= order_d;
    end
  end

  assign result_valid_o = out_valid_q;
  assign out_x_o        = geo_q.x;
  assign out_y_o        = geo_q.y;
  assign out_z_o        = geo_q.z;
  assign out_level_o    = geo_q.level;
  assign child_index_o  = geo_q.child;
  assign no_parent_o    = geo_q.no_parent;
  assign order_o        = order_q;

endmodule

@@ src/onu_geom.sv @@
// Geometry datapath of the octant navigation unit: child index, sibling, parent
// and face, edge and corner neighbors. Depends on onu_pkg.
module onu_geom (
  input  onu_pkg::cmd_e                  cmd_i,
  input  logic [onu_pkg::CoordW-1:0]     pos_x_i,
  input  logic [onu_pkg::CoordW-1:0]     pos_y_i,
  input  logic [onu_pkg::CoordW-1:0]     pos_z_i,
  input  logic [onu_pkg::LevelW-1:0]     level_i,
  input  logic [onu_pkg::SelW-1:0]       which_i,
  output onu_pkg::geo_res_t              res_o
);

  localparam logic [onu_pkg::LevelW-1:0] MaxLev = onu_pkg::LevelW'(onu_pkg::MaxLevel);

  logic [onu_pkg::LevelW-1:0]    lev;
  logic [onu_pkg::LevelW-1:0]    shamt;
  logic signed [onu_pkg::OutW-1:0] h, mh, x, y, z;
  logic signed [onu_pkg::OutW-1:0] s1;

  assign lev   = (level_i > MaxLev) ? MaxLev : level_i;
  assign shamt = MaxLev - lev;
  assign h     = onu_pkg::OutW'(1) << shamt;
  assign mh    = -h;
  assign x     = {{(onu_pkg::OutW-onu_pkg::CoordW){1'b0}}, pos_x_i};
  assign y     = {{(onu_pkg::OutW-onu_pkg::CoordW){1'b0}}, pos_y_i};
  assign z     = {{(onu_pkg::OutW-onu_pkg::CoordW){1'b0}}, pos_z_i};
  assign s1    = which_i[0] ? h : mh;

  always_comb begin
    res_o = '0;
    unique case (cmd_i)
      onu_pkg::CmdChild: begin
        res_o.child = {|(z & h), |(y & h), |(x & h)};
      end
      onu_pkg::CmdSibling: begin
        res_o.x     = (x & ~h) + (which_i[0] ? h : '0);
        res_o.y     = (y & ~h) + (which_i[1] ? h : '0);
        res_o.z     = (z & ~h) + (which_i[2] ? h : '0);
        res_o.level = lev;
      end
      onu_pkg::CmdParent: begin
        if (lev != '0) begin
          res_o.x     = x & ~h;
          res_o.y     = y & ~h;
          res_o.z     = z & ~h;
          res_o.level = lev - 1'b1;
        end else begin
          // The root has no parent: hand the octant back unchanged and flag it.
          res_o.x         = x;
          res_o.y         = y;
          res_o.z         = z;
          res_o.no_parent = 1'b1;
        end
      end
      onu_pkg::CmdFace: begin
        res_o.x = x + ((which_i == onu_pkg::FaceXNeg) ? mh :
                       (which_i == onu_pkg::FaceXPos) ? h : '0);
        res_o.y = y + ((which_i == onu_pkg::FaceYNeg) ? mh :
                       (which_i == onu_pkg::FaceYPos) ? h : '0);
        res_o.z = z + ((which_i == onu_pkg::FaceZNeg) ? mh :
                       (which_i == onu_pkg::FaceZPos) ? h : '0);
        res_o.level = lev;
      end
      onu_pkg::CmdEdge: begin
        res_o.x     = x;
        res_o.y     = y;
        res_o.z     = z;
        res_o.level = lev;
        if (which_i < onu_pkg::EdgeYFirst) begin
          res_o.y = y + s1;
          res_o.z = z + ((which_i < onu_pkg::EdgeXHigh) ? mh : h);
        end else if (which_i < onu_pkg::EdgeZFirst) begin
          res_o.x = x + s1;
          res_o.z = z + ((which_i < onu_pkg::EdgeYHigh) ? mh : h);
        end else begin
          res_o.x = x + s1;
          res_o.y = y + ((which_i < onu_pkg::EdgeZHigh) ? mh : h);
        end
      end
      onu_pkg::CmdCorner: begin
        res_o.x     = x + (which_i[0] ? h : mh);
        res_o.y     = y + (which_i[1] ? h : mh);
        res_o.z     = z + (which_i[2] ? h : mh);
        res_o.level = lev;
      end
      onu_pkg::CmdCompare, onu_pkg::CmdEncCompare: begin
        res_o = '0;
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

@@ src/onu_morton.sv @@
// Morton order comparator of the octant navigation unit, full and encoding-only
// forms. Depends on onu_pkg.
module onu_morton (
  input  onu_pkg::cmd_e                    cmd_i,
  input  logic [onu_pkg::CoordW-1:0]       pos_x_i,
  input  logic [onu_pkg::CoordW-1:0]       pos_y_i,
  input  logic [onu_pkg::CoordW-1:0]       pos_z_i,
  input  logic [onu_pkg::LevelW-1:0]       level_i,
  input  logic [onu_pkg::CoordW-1:0]       other_x_i,
  input  logic [onu_pkg::CoordW-1:0]       other_y_i,
  input  logic [onu_pkg::CoordW-1:0]       other_z_i,
  input  logic [onu_pkg::LevelW-1:0]       other_level_i,
  output logic signed [onu_pkg::OrderW-1:0] order_o
);

  logic [onu_pkg::CoordW-1:0] dx, dy, dz, a, b;
  logic                       x_leads, y_leads, same;
  logic signed [onu_pkg::OrderW-1:0] morton, lev_diff;

  assign dx = pos_x_i ^ other_x_i;
  assign dy = pos_y_i ^ other_y_i;
  assign dz = pos_z_i ^ other_z_i;

  // An axis leads when its highest differing bit is at or above every other axis.
  assign x_leads = dx > ((dy | dz) & ~dx);
  assign y_leads = dy > ((dx | dz) & ~dy);
  assign same    = ~|(dx | dy | dz);

  always_comb begin
    priority if (x_leads) begin
      a = pos_x_i;
      b = other_x_i;
    end else if (y_leads) begin
      a = pos_y_i;
      b = other_y_i;
    end else begin
      a = pos_z_i;
      b = other_z_i;
    end
  end

  assign morton   = (a > b) ? onu_pkg::OrderW'(1) :
                    (a < b) ? -onu_pkg::OrderW'(1) : '0;
  assign lev_diff = $signed({1'b0, level_i}) - $signed({1'b0, other_level_i});

  always_comb begin
    unique case (cmd_i)
      onu_pkg::CmdCompare:    order_o = same ? lev_diff : morton;
      onu_pkg::CmdEncCompare: order_o = morton;
      default:                order_o = '0;
    endcase
  end

endmodule
